[hw/rtl/siq_pkg.sv]
package siq_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 7;

    // Command codes carried on the cmd field.
    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // Status codes returned with every result.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POS   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // What the whole row of cells does in a given cycle.
    typedef enum logic [1:0] {
        SH_NONE,
        SH_INSERT,
        SH_REMOVE
    } t_shift_mode;

    // What a single cell does in a given cycle.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_FROM_SHALLOW,
        OP_FROM_DEEP
    } t_cell_op;

endpackage

[hw/rtl/siq_if.sv]
interface siq_in_if;
    import siq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic signed [POS_W-1:0]    position;
    logic signed [VALUE_W-1:0]  item_value;

    modport source (output valid, cmd, position, item_value, input ready);
    modport sink   (input valid, cmd, position, item_value, output ready);
endinterface

interface siq_out_if;
    import siq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  popped_value;
    logic [STATUS_W-1:0]        status;
    logic [FILL_W-1:0]          fill_count;
    logic                       is_empty;

    modport source (output valid, popped_value, status, fill_count, is_empty, input ready);
    modport sink   (input valid, popped_value, status, fill_count, is_empty, output ready);
endinterface

[hw/rtl/siq_cell.sv]
module siq_cell (
    input  logic                           i_clk,
    input  siq_pkg::t_cell_op              i_op,
    input  logic [siq_pkg::VALUE_W-1:0]    i_load,
    input  logic [siq_pkg::VALUE_W-1:0]    i_shallow,
    input  logic [siq_pkg::VALUE_W-1:0]    i_deep,
    output logic [siq_pkg::VALUE_W-1:0]    o_value
);
    import siq_pkg::*;

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;

    always_comb begin
        case (i_op)
            OP_LOAD:         n_value = i_load;
            OP_FROM_SHALLOW: n_value = i_shallow;
            OP_FROM_DEEP:    n_value = i_deep;
            default:         n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

[hw/rtl/siq_ctrl.sv]
module siq_ctrl #(
    parameter int DEPTH = 64,
    parameter int CW    = 7,
    parameter int PW    = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [siq_pkg::CMD_W-1:0]      i_cmd,
    input  logic [siq_pkg::POS_W-1:0]      i_position,
    input  logic [siq_pkg::VALUE_W-1:0]    i_top_value,
    output siq_pkg::t_shift_mode           o_mode,
    output logic [PW-1:0]                  o_pos,
    output logic [siq_pkg::VALUE_W-1:0]    o_popped,
    output logic [siq_pkg::STATUS_W-1:0]   o_status,
    output logic [CW-1:0]                  o_count
);
    import siq_pkg::*;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          full;
    logic          empty;
    logic          pos_nonneg;
    logic [PW-1:0] pos_u;
    logic [PW-1:0] count_w;

    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign pos_nonneg = !i_position[POS_W-1];
    assign pos_u      = PW'(i_position[POS_W-2:0]);
    assign count_w    = PW'(r_count);

    always_comb begin
        n_count  = r_count;
        o_mode   = SH_NONE;
        o_pos    = '0;
        o_popped = '0;
        o_status = ST_OK;
        case (i_cmd)
            CMD_PUSH: begin
                if (full) begin
                    o_status = ST_FULL;
                end else begin
                    o_mode  = SH_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP: begin
                if (empty) begin
                    o_status = ST_EMPTY;
                end else begin
                    o_mode   = SH_REMOVE;
                    o_popped = i_top_value;
                    n_count  = r_count - 1'b1;
                end
            end
            CMD_INSERT: begin
                if (full) begin
                    o_status = ST_FULL;
                end else begin
                    o_mode  = SH_INSERT;
                    n_count = r_count + 1'b1;
                    if (pos_nonneg) begin
                        o_pos = (pos_u > count_w) ? count_w : pos_u;
                    end
                end
            end
            CMD_REMOVE: begin
                if (empty) begin
                    o_status = ST_EMPTY;
                end else if (!pos_nonneg || pos_u >= count_w) begin
                    o_status = ST_POS;
                end else begin
                    o_mode  = SH_REMOVE;
                    o_pos   = pos_u;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        if (!i_accept) begin
            o_mode  = SH_NONE;
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = n_count;

endmodule

[hw/rtl/stack_with_positional_insert_remove_top.sv]
// Bounded stack of signed 32-bit values with the top at position 0. It takes
// push, pop, insert-at-position, remove-at-position and clear commands, one
// command per clock cycle, and returns one result per command: the popped
// value, a status code, the fill count and an empty flag after the command.
// The entries sit in a row of DEPTH cells; an insert or remove moves every
// cell below the chosen position one place at once, so no command takes
// longer for a deeper position. A result reaches the output in the cycle
// after its command's transfer and waits in an output
// register; a new command is taken in the same cycle as that result's
// transfer, so the only thing that slows the block is a stalled output.
// The contents need no clearing after reset: only the fill count and the output valid flag are reset.
module stack_with_positional_insert_remove_top #(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    siq_in_if.sink    i_in,
    siq_out_if.source o_out
);
    import siq_pkg::*;

    // Width of the fill count, and a compare width that also holds any
    // nonnegative command position.
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W - 1) ? CW : POS_W - 1;

    logic                accept;
    t_shift_mode         mode;
    logic [PW-1:0]       shift_pos;
    logic [VALUE_W-1:0]  res_popped;
    logic [STATUS_W-1:0] res_status;
    logic [CW-1:0]       res_count;
    logic [VALUE_W-1:0]  cell_value [DEPTH];

    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_popped;
    logic [STATUS_W-1:0] r_status;
    logic [FILL_W-1:0]   r_fill;
    logic                r_empty;

    // A command is taken whenever the output register is free or is being
    // drained in this very cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    siq_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW),
        .PW    (PW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cmd       (i_in.cmd),
        .i_position  (i_in.position),
        .i_top_value (cell_value[0]),
        .o_mode      (mode),
        .o_pos       (shift_pos),
        .o_popped    (res_popped),
        .o_status    (res_status),
        .o_count     (res_count)
    );

    // Each cell compares its own fixed index with the shift position. On an
    // insert, cells above the position hold, the cell at the position loads
    // the new value, and deeper cells take their shallower neighbor. On a
    // remove, cells at and below the position take their deeper neighbor.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [PW-1:0] IDX = PW'(i);

        t_cell_op           op;
        logic [VALUE_W-1:0] shallow;
        logic [VALUE_W-1:0] deep;

        always_comb begin
            case (mode)
                SH_INSERT: begin
                    if (shift_pos == IDX) begin
                        op = OP_LOAD;
                    end else if (shift_pos < IDX) begin
                        op = OP_FROM_SHALLOW;
                    end else begin
                        op = OP_HOLD;
                    end
                end
                SH_REMOVE: begin
                    op = (shift_pos <= IDX) ? OP_FROM_DEEP : OP_HOLD;
                end
                default: op = OP_HOLD;
            endcase
        end

        // The top cell never shifts in from above, and the bottom cell only
        // ever takes from below a slot that is no longer counted.
        if (i == 0) begin : g_first
            assign shallow = i_in.item_value;
        end else begin : g_mid_s
            assign shallow = cell_value[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign deep = cell_value[i];
        end else begin : g_mid_d
            assign deep = cell_value[i+1];
        end

        siq_cell u_cell (
            .i_clk     (i_clk),
            .i_op      (op),
            .i_load    (i_in.item_value),
            .i_shallow (shallow),
            .i_deep    (deep),
            .o_value   (cell_value[i])
        );
    end

    // Output register holding the result of the latest command until its
    // transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_popped <= res_popped;
            r_status <= res_status;
            r_fill   <= FILL_W'(res_count);
            r_empty  <= (res_count == '0);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.popped_value = r_popped;
    assign o_out.status       = r_status;
    assign o_out.fill_count   = r_fill;
    assign o_out.is_empty     = r_empty;

endmodule
